### rtl/core/stp_pkg.sv
package stp_pkg;

  localparam int unsigned MaxColumnsDefault = 256;
  localparam int unsigned QueueDepth        = 2;

  localparam logic [15:0] SpaceCode = 16'h0020;
  localparam logic [7:0]  CrCode    = 8'h0D;

  typedef enum logic [1:0] {
    CMD_CHAR  = 2'd0,
    CMD_CR    = 2'd1,
    CMD_FLUSH = 2'd2
  } cmd_kind_e;

  // One classified cell on its way from the front to the back.
  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  spaces;
    logic [15:0] code;
  } cmd_t;

endpackage

### rtl/core/selection_text_packer_utf8.sv
// Selection text packer: turns selected screen cells (16-bit codes) into
// UTF-8 bytes, with runs of spaces carried as a count.
//
// Input channel: drive char_code_i, row_end_i and selection_end_i with push
// high; the cell is taken at a clock edge where push is high and full is low.
// Result channel: while empty is low, the oldest result byte sits on
// spaces_before_o, byte_value_o, has_byte_o and last_o; pop takes it.
//
// A front stage classifies each cell and keeps the pending space count; a
// two-entry command queue feeds a back stage with a single byte-wide output
// register. A cell's first result passes through the queue and then that
// register. Throughput, set by that register: one result per cycle while the
// receiver pops; a cell yields 1 to 3 results (its UTF-8 length). Spaces that
// only add to the count yield no result.
//
// Reset empties the queue and the output register and clears the space count.
// When the receiver stalls, the output register holds, the queue fills,
// and full rises after two commands are waiting.
module selection_text_packer_utf8 import stp_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = MaxColumnsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [15:0] char_code_i,
  input  logic        row_end_i,
  input  logic        selection_end_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  spaces_before_o,
  output logic [7:0]  byte_value_o,
  output logic        has_byte_o,
  output logic        last_o
);

  logic accept;
  logic cmd_push, cmd_pop, cmd_empty;
  cmd_t cmd_in, cmd_head;

  // hold off new cells whenever the command queue is full
  assign accept = push && !full;

  stp_front #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .char_code_i    (char_code_i),
    .row_end_i      (row_end_i),
    .selection_end_i(selection_end_i),
    .cmd_push_o     (cmd_push),
    .cmd_o          (cmd_in)
  );

  stp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (full),
    .pop_i  (cmd_pop),
    .empty_o(cmd_empty),
    .data_o (cmd_head)
  );

  stp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_empty_i    (cmd_empty),
    .cmd_i          (cmd_head),
    .cmd_pop_o      (cmd_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .spaces_before_o(spaces_before_o),
    .byte_value_o   (byte_value_o),
    .has_byte_o     (has_byte_o),
    .last_o         (last_o)
  );

endmodule

### rtl/core/stp_front.sv
module stp_front import stp_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = MaxColumnsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [15:0] char_code_i,
  input  logic        row_end_i,
  input  logic        selection_end_i,
  output logic        cmd_push_o,
  output cmd_t        cmd_o
);

  localparam int unsigned LimitInt   = (MAX_COLUMNS - 1 > 255) ? 255 : MAX_COLUMNS - 1;
  localparam logic [7:0]  SpaceLimit = 8'(LimitInt);

  logic [7:0] pending_d, pending_q;
  logic [7:0] pending_inc;
  logic       is_space;

  assign is_space    = (char_code_i == SpaceCode);
  assign pending_inc = (pending_q >= SpaceLimit) ? SpaceLimit : pending_q + 8'd1;

  always_comb begin
    pending_d   = pending_q;
    cmd_push_o  = 1'b0;
    cmd_o.kind  = CMD_CHAR;
    cmd_o.spaces = pending_q;
    cmd_o.code  = char_code_i;
    if (accept_i) begin
      pending_d = 8'd0;
      if (is_space) begin
        if (row_end_i) begin
          // drop trailing spaces, send a carriage return instead
          cmd_push_o   = 1'b1;
          cmd_o.kind   = CMD_CR;
          cmd_o.spaces = 8'd0;
        end else if (selection_end_i) begin
          cmd_push_o   = 1'b1;
          cmd_o.kind   = CMD_FLUSH;
          cmd_o.spaces = pending_inc;
        end else begin
          pending_d = pending_inc;
        end
      end else begin
        cmd_push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 8'd0;
    end else begin
      pending_q <= pending_d;
    end
  end

endmodule

### rtl/core/stp_queue.sv
module stp_queue import stp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t data_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam logic [PtrW:0] DepthCnt = (PtrW + 1)'(QueueDepth);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(QueueDepth - 1);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == DepthCnt);
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### rtl/core/stp_back.sv
module stp_back import stp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_empty_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] spaces_before_o,
  output logic [7:0] byte_value_o,
  output logic       has_byte_o,
  output logic       last_o
);

  logic       out_valid_q;
  logic [7:0] spaces_q, byte_q;
  logic       has_q, last_q;
  logic [1:0] idx_d, idx_q;
  logic [1:0] nbytes;
  logic       load;
  logic [7:0] byte_d, spaces_d;
  logic       has_d, last_d;

  assign load = !cmd_empty_i && (!out_valid_q || pop_i);

  always_comb begin
    nbytes = 2'd1;
    if (cmd_i.kind == CMD_CHAR) begin
      if (cmd_i.code[15:11] != 5'd0) begin
        nbytes = 2'd3;
      end else if (cmd_i.code[10:7] != 4'd0) begin
        nbytes = 2'd2;
      end
    end
  end

  always_comb begin
    spaces_d = (idx_q == 2'd0) ? cmd_i.spaces : 8'd0;
    has_d    = 1'b1;
    last_d   = (idx_q == nbytes - 2'd1);
    byte_d   = 8'd0;
    case (cmd_i.kind)
      CMD_CR: begin
        byte_d = CrCode;
      end
      CMD_FLUSH: begin
        has_d = 1'b0;
      end
      CMD_CHAR: begin
        case (idx_q)
          2'd0: begin
            case (nbytes)
              2'd1:    byte_d = {1'b0, cmd_i.code[6:0]};
              2'd2:    byte_d = {3'b110, cmd_i.code[10:6]};
              default: byte_d = {4'b1110, cmd_i.code[15:12]};
            endcase
          end
          2'd1: begin
            byte_d = (nbytes == 2'd2) ? {2'b10, cmd_i.code[5:0]}
                                      : {2'b10, cmd_i.code[11:6]};
          end
          default: begin
            byte_d = {2'b10, cmd_i.code[5:0]};
          end
        endcase
      end
      default: begin
        has_d = 1'b0;
      end
    endcase
  end

  // Advance through the bytes of the head command; release it on its last byte.
  assign cmd_pop_o = load && last_d;
  assign idx_d     = load ? (last_d ? 2'd0 : idx_q + 2'd1) : idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      spaces_q <= spaces_d;
      byte_q   <= byte_d;
      has_q    <= has_d;
      last_q   <= last_d;
    end
  end

  assign empty_o         = !out_valid_q;
  assign spaces_before_o = spaces_q;
  assign byte_value_o    = byte_q;
  assign has_byte_o      = has_q;
  assign last_o          = last_q;

endmodule
